/* rtl/shader_text_tokenizer_unit_assert.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef SHADER_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SHADER_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define STTOK_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled at the rising clock edge.
`define STTOK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sttok_pkg.sv */
package sttok_pkg;

  // Token kinds as they appear on the result channel.
  typedef enum logic [2:0] {
    TK_IDENT   = 3'd0,
    TK_LITERAL = 3'd1,
    TK_PUNCT   = 3'd2,
    TK_ASSIGN  = 3'd3,
    TK_EQUAL   = 3'd4,
    TK_UNKNOWN = 3'd5,
    TK_END     = 3'd6
  } tok_kind_t;

  // Kind of the token that is still growing.
  typedef enum logic [1:0] {
    PK_NONE    = 2'd0,
    PK_IDENT   = 2'd1,
    PK_LITERAL = 2'd2,
    PK_ASSIGN  = 2'd3
  } pend_kind_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Entries in the queue between front and back ends.
  localparam int QUEUE_DEPTH = 4;

  // One token: kind, start, length, first byte, done and run-last flags.
  function automatic int tok_bits(input int offset_bits, input int length_bits);
    return 3 + offset_bits + length_bits + 8 + 2;
  endfunction

  // One queue entry: two tokens plus a flag that says both are used.
  function automatic int entry_bits(input int offset_bits, input int length_bits);
    return 1 + 2 * tok_bits(offset_bits, length_bits);
  endfunction

endpackage

/* rtl/sttok_if.sv */
// Input channel: one text byte per transaction.
interface sttok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// Result channel: one token per transaction.
interface sttok_out_if #(
  parameter int OFFSET_BITS = 16,
  parameter int LENGTH_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_kind;
  logic [OFFSET_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0] token_length;
  logic [7:0]             first_byte;
  logic                   text_done;
  logic                   run_last;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output first_byte, output text_done, output run_last, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input first_byte, input text_done, input run_last, output ready);
endinterface

/* rtl/sttok_front.sv */
module sttok_front import sttok_pkg::*; #(
  parameter int OFFSET_BITS = 16,
  parameter int LENGTH_BITS = 8,
  localparam int EntryW = entry_bits(OFFSET_BITS, LENGTH_BITS)
) (
  input  logic              clk,
  input  logic              rst_n,
  sttok_in_if.sink          in_ch,
  input  q_stat_t           q_stat,
  output logic              push,
  output logic [EntryW-1:0] push_data
);

  `include "shader_text_tokenizer_unit_assert.svh"

  typedef struct packed {
    tok_kind_t              kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] length;
    logic [7:0]             first;
    logic                   done;
    logic                   run_last;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t1;
    tok_t t0;
  } entry_t;

  localparam logic [OFFSET_BITS-1:0] OffsetMax = '1;
  localparam logic [LENGTH_BITS-1:0] LengthMax = '1;

  pend_kind_t             pend_kind_r,  pend_kind_nxt;
  logic [OFFSET_BITS-1:0] pend_start_r, pend_start_nxt;
  logic [LENGTH_BITS-1:0] pend_len_r,   pend_len_nxt;
  logic [7:0]             pend_first_r, pend_first_nxt;
  logic [OFFSET_BITS-1:0] pos_r,        pos_nxt;

  logic       acc;
  logic [7:0] c;
  logic       last;
  logic       is_space, is_alpha, is_digit, is_punct;
  logic       consumed;
  logic       va, vb, vc, ve;
  tok_t       tok_a, tok_b, tok_c, tok_e;
  pend_kind_t k1;
  logic [OFFSET_BITS-1:0] start1;
  logic [LENGTH_BITS-1:0] len1;
  logic [7:0]             first1;
  entry_t     ent;

  function automatic tok_kind_t flush_kind(input pend_kind_t pk);
    tok_kind_t k;
    case (pk)
      PK_IDENT:   k = TK_IDENT;
      PK_LITERAL: k = TK_LITERAL;
      default:    k = TK_ASSIGN;
    endcase
    return k;
  endfunction

  assign in_ch.ready = !q_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = in_ch.text_byte;
  assign last        = in_ch.text_last;

  always_comb begin
    is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    is_alpha = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    is_digit = (c inside {[8'h30:8'h39]});
    is_punct = (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LBRACE, CH_RBRACE,
                          CH_LPAREN, CH_RPAREN, CH_SEMI, CH_DOT});

    case (pend_kind_r)
      PK_IDENT:   consumed = is_alpha || (c == CH_UNDER);
      PK_LITERAL: consumed = is_digit || (c == CH_DOT) || (c == CH_F);
      PK_ASSIGN:  consumed = (c == CH_EQ);
      default:    consumed = 1'b0;
    endcase

    // Token closed by this byte, or an equality token completed by it.
    va    = (pend_kind_r != PK_NONE) && (!consumed || (pend_kind_r == PK_ASSIGN));
    tok_a = '0;
    tok_a.start = pend_start_r;
    if (pend_kind_r == PK_ASSIGN && consumed) begin
      tok_a.kind   = TK_EQUAL;
      tok_a.length = LENGTH_BITS'(2);
      tok_a.first  = CH_EQ;
    end else begin
      tok_a.kind   = flush_kind(pend_kind_r);
      tok_a.length = pend_len_r;
      tok_a.first  = pend_first_r;
    end

    // Pending state once this byte has been applied.
    k1     = pend_kind_r;
    start1 = pend_start_r;
    len1   = pend_len_r;
    first1 = pend_first_r;
    vb     = 1'b0;
    tok_b  = '0;
    tok_b.start  = pos_r;
    tok_b.length = LENGTH_BITS'(1);
    tok_b.first  = c;
    tok_b.kind   = TK_PUNCT;
    if (consumed) begin
      if (pend_kind_r == PK_ASSIGN) begin
        k1 = PK_NONE;
      end else if (pend_len_r != LengthMax) begin
        len1 = pend_len_r + 1'b1;
      end
    end else begin
      k1 = PK_NONE;
      if (is_space) begin
        vb = 1'b0;
      end else if (is_punct) begin
        vb = 1'b1;
      end else if (c == CH_EQ || is_alpha || is_digit) begin
        k1     = (c == CH_EQ) ? PK_ASSIGN : (is_alpha ? PK_IDENT : PK_LITERAL);
        start1 = pos_r;
        len1   = LENGTH_BITS'(1);
        first1 = c;
      end else begin
        vb         = 1'b1;
        tok_b.kind = TK_UNKNOWN;
      end
    end

    // End of text flushes whatever is still pending.
    vc    = last && (k1 != PK_NONE);
    tok_c = '0;
    tok_c.kind   = flush_kind(k1);
    tok_c.start  = start1;
    tok_c.length = len1;
    tok_c.first  = first1;

    ve    = last && !va && !vb && !vc;
    tok_e = '0;
    tok_e.kind  = TK_END;
    tok_e.start = pos_r;

    ent = '0;
    if (va)      ent.t0 = tok_a;
    else if (vb) ent.t0 = tok_b;
    else if (vc) ent.t0 = tok_c;
    else         ent.t0 = tok_e;
    ent.two = va && (vb || vc);
    ent.t1  = vb ? tok_b : tok_c;
    if (ent.two) begin
      ent.t1.run_last = 1'b1;
      ent.t1.done     = last;
    end else begin
      ent.t0.run_last = 1'b1;
      ent.t0.done     = last;
    end

    if (last) begin
      pend_kind_nxt  = PK_NONE;
      pend_start_nxt = '0;
      pend_len_nxt   = '0;
      pend_first_nxt = '0;
      pos_nxt        = '0;
    end else begin
      pend_kind_nxt  = k1;
      pend_start_nxt = start1;
      pend_len_nxt   = len1;
      pend_first_nxt = first1;
      pos_nxt        = (pos_r == OffsetMax) ? pos_r : pos_r + 1'b1;
    end
  end

  assign push      = acc && (va || vb || vc || ve);
  assign push_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_kind_r  <= PK_NONE;
      pend_start_r <= '0;
      pend_len_r   <= '0;
      pend_first_r <= '0;
      pos_r        <= '0;
    end else if (acc) begin
      pend_kind_r  <= pend_kind_nxt;
      pend_start_r <= pend_start_nxt;
      pend_len_r   <= pend_len_nxt;
      pend_first_r <= pend_first_nxt;
      pos_r        <= pos_nxt;
    end
  end

  // An end marker is only produced when the final byte yields nothing else.
  `STTOK_ASSERT_IMPLY(a_end_alone, clk, rst_n, push && (ent.t0.kind == TK_END),
                      !ent.two && ent.t0.done, "end marker shares an entry")

endmodule

/* rtl/sttok_queue.sv */
module sttok_queue import sttok_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output q_stat_t          q_stat
);

  `include "shader_text_tokenizer_unit_assert.svh"

  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r,  count_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (count_r == DepthC);
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  `STTOK_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= DepthC,
                      "queue count above depth")
  `STTOK_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !q_stat.full && !do_pop,
                     count_r == $past(count_r) + 1'b1, "push without pop did not grow queue")

endmodule

/* rtl/sttok_back.sv */
module sttok_back import sttok_pkg::*; #(
  parameter int OFFSET_BITS = 16,
  parameter int LENGTH_BITS = 8,
  localparam int EntryW = entry_bits(OFFSET_BITS, LENGTH_BITS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [EntryW-1:0] head_data,
  input  q_stat_t           q_stat,
  output logic              pop,
  sttok_out_if.source       out_ch
);

  `include "shader_text_tokenizer_unit_assert.svh"

  typedef struct packed {
    tok_kind_t              kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] length;
    logic [7:0]             first;
    logic                   done;
    logic                   run_last;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t1;
    tok_t t0;
  } entry_t;

  entry_t head;
  tok_t   tok_sel;
  tok_t   out_tok_r;
  logic   out_valid_r, out_valid_nxt;
  logic   sub_r, sub_nxt;
  logic   load;

  always_comb begin
    head    = entry_t'(head_data);
    load    = !q_stat.empty && (!out_valid_r || out_ch.ready);
    tok_sel = sub_r ? head.t1 : head.t0;
    pop     = load && (sub_r || !head.two);
    sub_nxt = load ? (!sub_r && head.two) : sub_r;
    if (load)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_tok_r <= tok_sel;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_kind   = out_tok_r.kind;
  assign out_ch.token_start  = out_tok_r.start;
  assign out_ch.token_length = out_tok_r.length;
  assign out_ch.first_byte   = out_tok_r.first;
  assign out_ch.text_done    = out_tok_r.done;
  assign out_ch.run_last     = out_tok_r.run_last;

  // The second token is only selected while a two-token entry is at the head.
  `STTOK_ASSERT_IMPLY(a_sub_two, clk, rst_n, sub_r, !q_stat.empty && head.two,
                      "second token selected without a two-token entry")

endmodule

/* rtl/shader_text_tokenizer_unit.sv */
// Streaming shader-text tokenizer. Each input transaction carries one byte of
// source text and a flag for the final byte; each output transaction carries
// one token: its kind, start offset (saturating), length (saturating at the
// top of LENGTH_BITS, zero for the end marker), first byte, a text-done flag
// on the final token of the text and a run-last flag on the last token caused
// by a byte. Whitespace is dropped, identifiers and literals are held until a
// byte ends them, and at the final byte any pending token is flushed; if the
// final byte yields no token, an end marker is sent instead. Timing: the block
// takes one byte per cycle while its four-entry token queue has room; a byte's
// tokens are written into that queue and then loaded into the output register.
// A byte yields up to two tokens and the output register sends one token per
// cycle while the receiver is ready, so the sustained rate is set by the output.
module shader_text_tokenizer_unit import sttok_pkg::*; #(
  parameter int OFFSET_BITS = 16,
  parameter int LENGTH_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  sttok_in_if.sink    in_ch,
  sttok_out_if.source out_ch
);

  `include "shader_text_tokenizer_unit_assert.svh"

  localparam int EntryW = entry_bits(OFFSET_BITS, LENGTH_BITS);

  // Front end to queue: a push carries every token one byte produced.
  logic              push;
  logic [EntryW-1:0] push_data;

  // Queue to back end: the oldest entry and the pop that retires it.
  logic              pop;
  logic [EntryW-1:0] head_data;
  q_stat_t           q_stat;

  // The front end classifies each byte, tracks the pending token and the
  // text offset, and turns the byte into zero, one or two tokens.
  sttok_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // The queue decouples input from output so that an output stall does not
  // stop input transactions until the queue fills.
  sttok_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_stat    (q_stat)
  );

  // The back end sends the tokens of each entry in order through a
  // registered output stage.
  sttok_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_data (head_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // The final token of a text is always the last token of its byte.
  `STTOK_ASSERT_IMPLY(a_done_is_run_last, clk, rst_n, out_ch.valid && out_ch.text_done,
                      out_ch.run_last, "text done without run last")

endmodule
